// ----- design/abp_pkg.sv -----
// Shared types, operation codes and pixel helper functions for the ARGB blend unit.
// No dependencies; used by every module of the block.
package abp_pkg;

	typedef enum logic [1:0] {
		K_BLEND   = 2'd0,
		K_COPY    = 2'd1,
		K_MIX     = 2'd2,
		K_CONVERT = 2'd3
	} kind_t;

	// stage 1 result
	typedef struct packed {
		kind_t       kind;
		logic        fmt;
		logic        we;
		logic [31:0] pass;
		logic [23:0] bk;
		logic [23:0] fg;
		logic [7:0]  a2;
		logic [7:0]  mix_a;
		logic [15:0] prod;
	} front_t;

	// side payload carried alongside the divider
	typedef struct packed {
		kind_t       kind;
		logic        fmt;
		logic        we;
		logic [31:0] pass;
		logic [23:0] bk;
		logic [23:0] fg;
		logic [7:0]  a2;
		logic [7:0]  alpha;
	} side_t;

	// divider state: partial remainder, partial quotient, divisor
	typedef struct packed {
		logic [7:0] rem;
		logic [8:0] q;
		logic [7:0] d;
	} div_t;

	function automatic logic [31:0] widen(input logic [15:0] p);
		logic [31:0] c;
		c = {8'h00, p[14:10], 3'b000, p[9:5], 3'b000, p[4:0], 3'b000};
		if (p[15]) begin
			c[31:24] = 8'hff;
		end
		return c;
	endfunction

	function automatic logic [31:0] narrow(input logic [31:0] c);
		return {16'h0000, c[31], c[23:19], c[15:11], c[7:3]};
	endfunction

	// floor(x/255), exact for x up to 65025
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		return s[15:8];
	endfunction

	// one restoring division step: returns {quotient bit, new remainder}
	function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
			input logic [7:0] d);
		logic [8:0] r2;
		logic [8:0] diff;
		r2 = {rem, nb};
		diff = r2 - {1'b0, d};
		if (r2 >= {1'b0, d}) begin
			return {1'b1, diff[7:0]};
		end
		return {1'b0, r2[7:0]};
	endfunction

endpackage

// ----- design/abp_front.sv -----
// Stage 1 of the blend unit: widening, alpha products and copy/convert results.
// Depends on abp_pkg.
module abp_front import abp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  kind_t       kind,
	input  logic [31:0] bkg_pixel,
	input  logic [31:0] fg_color,
	input  logic        fmt,
	output logic        v_s1,
	output front_t      f_s1
);

	logic [31:0] bk8;
	logic [7:0]  a1, a2;
	logic [15:0] a12;
	logic [8:0]  asum;
	front_t      nxt;

	always_comb begin
		bk8 = fmt ? widen(bkg_pixel[15:0]) : bkg_pixel;
		a1 = bk8[31:24];
		a2 = fg_color[31:24];
		a12 = a1 * a2;
		asum = {1'b0, a1} + {1'b0, a2} - {1'b0, a12[15:8]};
		nxt.kind = kind;
		nxt.fmt = fmt;
		nxt.bk = bk8[23:0];
		nxt.fg = fg_color[23:0];
		nxt.a2 = a2;
		nxt.mix_a = asum[8] ? 8'hff : asum[7:0];
		nxt.prod = (8'hff ^ a1) * (8'hff ^ a2);
		nxt.we = 1'b1;
		nxt.pass = '0;
		unique case (kind)
			K_COPY: begin
				nxt.we = fg_color[15];
				if (fg_color[15]) begin
					nxt.pass = fmt ? {16'h0000, fg_color[15:0]} : widen(fg_color[15:0]);
				end else begin
					nxt.pass = fmt ? {16'h0000, bkg_pixel[15:0]} : bkg_pixel;
				end
			end
			K_CONVERT: begin
				nxt.we = 1'b0;
				nxt.pass = fmt ? narrow(fg_color) : fg_color;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1 <= nxt;
		end
	end

endmodule

// ----- design/abp_div_stage.sv -----
// One registered stage of the mix-ratio divider: three restoring steps.
// Depends on abp_pkg.
module abp_div_stage import abp_pkg::*; (
	input  logic       clk,
	input  logic       adv,
	input  div_t       din,
	input  logic [2:0] nbits,   // dividend bits for the three steps, msb first
	output div_t       dout
);

	div_t nxt;
	logic [8:0] st0, st1, st2;

	always_comb begin
		st0 = div_step(din.rem, nbits[2], din.d);
		st1 = div_step(st0[7:0], nbits[1], din.d);
		st2 = div_step(st1[7:0], nbits[0], din.d);
		nxt.rem = st2[7:0];
		nxt.q = {din.q[5:0], st0[8], st1[8], st2[8]};
		nxt.d = din.d;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dout <= nxt;
		end
	end

endmodule

// ----- design/abp_chan.sv -----
// Stages 5 and 6: per-channel products, rounding, result assembly and narrowing.
// Depends on abp_pkg.
module abp_chan import abp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        v_in,
	input  side_t       side,
	input  logic [8:0]  t,
	output logic        v_s6,
	output logic [31:0] pix_s6,
	output logic        we_s6,
	output kind_t       kind_s6
);

	logic               v_s5;
	side_t              side_s5;
	logic signed [18:0] p_s5 [3];
	logic signed [18:0] p_nxt [3];
	logic [7:0]         c [3];
	logic [31:0]        res;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_nxt[i] = signed'({1'b0, side.fg[8*i +: 8]} - {1'b0, side.bk[8*i +: 8]})
				* signed'({1'b0, (side.kind == K_BLEND) ? {1'b0, side.a2} : t});
		end
	end

	always_comb begin
		logic signed [18:0] pr;
		for (int i = 0; i < 3; i++) begin
			// blend truncates toward zero, mix floors
			pr = p_s5[i] + ((side_s5.kind == K_BLEND && p_s5[i] < 0) ? 19'sd255 : 19'sd0);
			pr = pr >>> 8;
			c[i] = side_s5.bk[8*i +: 8] + pr[7:0];
		end
		res = {side_s5.alpha, c[2], c[1], c[0]};
		if (side_s5.kind == K_MIX && side_s5.alpha == 8'h00) begin
			res = '0;
		end
		if (side_s5.fmt) begin
			res = narrow(res);
		end
		if (side_s5.kind == K_COPY || side_s5.kind == K_CONVERT) begin
			res = side_s5.pass;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_in;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side;
			for (int i = 0; i < 3; i++) begin
				p_s5[i] <= p_nxt[i];
			end
			pix_s6 <= res;
			we_s6 <= side_s5.we;
			kind_s6 <= side_s5.kind;
		end
	end

endmodule

// ----- design/argb_pixel_blend_unit_top.sv -----
// Top level of the ARGB pixel blend unit: stream ports, format register, pipeline.
// Depends on abp_pkg, abp_front, abp_div_stage and abp_chan.

// Pixel blend unit for a blitter. Each input beat carries a background pixel, a
// foreground color and an operation (blend, copy on 1-bit alpha, mix, convert); each
// output beat carries the new pixel in canvas format and a write enable. One beat per
// clock is accepted and delivered while m_tready does not stall the pipeline.
// The depth is set by the mix ratio divider (three stages, three quotient bits each)
// followed by a channel multiply stage and a round/assemble stage. The whole pipeline
// advances together whenever the output register is empty or being taken, so a stall
// on m_tready holds every stage and s_tready follows it in the same cycle.
// pixel_format (reset 1, ARGB1555) is written through pixel_format_we; change it only
// while no beat is in flight.
module argb_pixel_blend_unit_top import abp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_format_we,
	input  logic        pixel_format_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // [31:0] bkg_pixel, [63:32] fg_color
	input  logic [1:0]  s_tuser,    // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] new_pixel
	output logic        m_tuser     // [0] write_enable
);

	logic   fmt_q;
	logic   adv;
	logic   v_s1, v_s2, v_s3, v_s4;
	front_t f_s1;
	side_t  side_s2, side_s3, side_s4, side_nxt;
	div_t   div_in, div_s2, div_s3, div_s4;
	kind_t  kind_s6;
	logic   we_s6;

	// pipeline moves when the output slot is free or draining
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b1;
		end else if (pixel_format_we) begin
			fmt_q <= pixel_format_wdata;
		end
	end

	abp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (s_tvalid),
		.kind       (kind_t'(s_tuser)),
		.bkg_pixel  (s_tdata[31:0]),
		.fg_color   (s_tdata[63:32]),
		.fmt        (fmt_q),
		.v_s1       (v_s1),
		.f_s1       (f_s1)
	);

	// stage 2 side data: final alpha for blend (inverted product over 255) or mix
	always_comb begin
		side_nxt.kind = f_s1.kind;
		side_nxt.fmt = f_s1.fmt;
		side_nxt.we = f_s1.we;
		side_nxt.pass = f_s1.pass;
		side_nxt.bk = f_s1.bk;
		side_nxt.fg = f_s1.fg;
		side_nxt.a2 = f_s1.a2;
		side_nxt.alpha = (f_s1.kind == K_BLEND) ? ~div255(f_s1.prod) : f_s1.mix_a;
		// t = (a2 << 8) / A; quotient fits in 9 bits since a2 <= A,
		// so the upper dividend bits collapse to a starting remainder of a2 >> 1
		div_in.rem = {1'b0, f_s1.a2[7:1]};
		div_in.q = '0;
		div_in.d = f_s1.mix_a;
	end

	abp_div_stage u_div0 (
		.clk (clk), .adv (adv), .din (div_in), .nbits ({f_s1.a2[0], 2'b00}), .dout (div_s2)
	);
	abp_div_stage u_div1 (
		.clk (clk), .adv (adv), .din (div_s2), .nbits (3'b000), .dout (div_s3)
	);
	abp_div_stage u_div2 (
		.clk (clk), .adv (adv), .din (div_s3), .nbits (3'b000), .dout (div_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_nxt;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	abp_chan u_chan (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_in    (v_s4),
		.side    (side_s4),
		.t       (div_s4.q),
		.v_s6    (m_tvalid),
		.pix_s6  (m_tdata),
		.we_s6   (we_s6),
		.kind_s6 (kind_s6)
	);

	assign m_tuser = we_s6;

	// write enable only drops for copy or convert
	a_we_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (kind_s6 == K_COPY || kind_s6 == K_CONVERT))
		else $error("write enable low on blend or mix");

	// a beat in stage 1 reaches stage 2 when the pipe advances
	a_adv_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1) |=> v_s2)
		else $error("beat lost between stage 1 and 2");

	// a held pipe keeps its stage 4 beat
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && v_s4) |=> v_s4)
		else $error("stage 4 dropped during stall");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for argb_pixel_blend_unit_top: directed and random pixel ops.
// Depends on abp_pkg (kind codes) and the blend unit RTL; predicts each result in-bench.
module testbench;
	import abp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        pixel_format_we;
	logic        pixel_format_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;    // [31:0] bkg_pixel, [63:32] fg_color
	logic [1:0]  s_tuser;    // [1:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // [31:0] new_pixel
	logic        m_tuser;    // [0] write_enable

	typedef struct packed {
		logic [31:0] pixel;
		logic        we;
	} pix_res_t;

	pix_res_t pending_pix[$];
	logic     fmt_1555;
	int       err_cnt;
	int       idle_cycles;
	int       stall_q;

	argb_pixel_blend_unit_top u_dut (.*);

	// clock: period 4
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ---- predictor ----
	function automatic logic [31:0] to8888(input logic [15:0] p);
		logic [31:0] c;
		c = {p[15] ? 8'hff : 8'h00, p[14:10], 3'b0, p[9:5], 3'b0, p[4:0], 3'b0};
		return c;
	endfunction

	function automatic logic [31:0] to1555(input logic [31:0] c);
		return {16'h0, c[31], c[23:19], c[15:11], c[7:3]};
	endfunction

	function automatic logic [7:0] step_toward(input int a, input int f, input int b);
		if (f > b) begin
			return 8'(b + (((f - b) * a) >> 8));
		end
		return 8'(b - (((b - f) * a) >> 8));
	endfunction

	// signed floor of (f-b)*t/256 added to b
	function automatic logic [7:0] lerp(input int b, input int f, input int t);
		int p;
		int q;
		p = (f - b) * t;
		q = (p >= 0) ? (p / 256) : -((-p + 255) / 256);
		return 8'(b + q);
	endfunction

	function automatic logic [31:0] blend_px(input logic [31:0] bk, input logic [31:0] fg);
		int a1;
		int a2;
		logic [7:0] a;
		a1 = bk[31:24];
		a2 = fg[31:24];
		a = 8'(255 - ((255 - a1) * (255 - a2)) / 255);
		return {a, step_toward(a2, fg[23:16], bk[23:16]),
			step_toward(a2, fg[15:8], bk[15:8]), step_toward(a2, fg[7:0], bk[7:0])};
	endfunction

	function automatic logic [31:0] mix_px(input logic [31:0] bk, input logic [31:0] fg);
		int a1;
		int a2;
		int a;
		int t;
		a1 = bk[31:24];
		a2 = fg[31:24];
		a = a1 + a2 - ((a1 * a2) >> 8);
		if (a > 255) begin
			a = 255;
		end
		if (a == 0) begin
			return 32'h0;
		end
		t = (a2 * 256) / a;
		return {a[7:0], lerp(bk[23:16], fg[23:16], t), lerp(bk[15:8], fg[15:8], t),
			lerp(bk[7:0], fg[7:0], t)};
	endfunction

	function automatic pix_res_t predict_pixel(input kind_t k, input logic [31:0] bk,
			input logic [31:0] fg);
		pix_res_t r;
		logic [31:0] bk8;
		bk8 = fmt_1555 ? to8888(bk[15:0]) : bk;
		r.we = 1'b1;
		case (k)
			K_BLEND: begin
				r.pixel = blend_px(bk8, fg);
				if (fmt_1555) r.pixel = to1555(r.pixel);
			end
			K_COPY: begin
				if (fg[15]) begin
					r.pixel = fmt_1555 ? {16'h0, fg[15:0]} : to8888(fg[15:0]);
				end else begin
					r.we = 1'b0;
					r.pixel = fmt_1555 ? {16'h0, bk[15:0]} : bk;
				end
			end
			K_MIX: begin
				r.pixel = mix_px(bk8, fg);
				if (fmt_1555) r.pixel = to1555(r.pixel);
			end
			default: begin
				r.we = 1'b0;
				r.pixel = fmt_1555 ? to1555(fg) : fg;
			end
		endcase
		return r;
	endfunction

	// ---- stimulus helpers ----
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// send one beat; prediction is taken at acceptance, valid stays up for the next call
	task automatic send_pixel(input kind_t k, input logic [31:0] bk, input logic [31:0] fg,
			input bit gaps = 1'b1);
		int gap;
		gap = gaps ? rand_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {fg, bk};
		s_tuser <= k;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_pix.push_back(predict_pixel(k, bk, fg));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_pix.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// register written only with pipeline empty
	task automatic set_format(input logic f);
		drain();
		pixel_format_we <= 1'b1;
		pixel_format_wdata <= f;
		@(posedge clk);
		pixel_format_we <= 1'b0;
		fmt_1555 = f;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rnd32();
		return $urandom();
	endfunction

	// alpha chosen often at the extremes
	function automatic logic [7:0] rnd_alpha();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// ---- tests ----
	task automatic test_directed();
		kind_t k;
		for (int f = 1; f >= 0; f--) begin
			set_format(f[0]);
			for (int i = 0; i < 4; i++) begin
				k = kind_t'(i);
				send_pixel(k, 32'h0000_0000, 32'hffff_ffff, 1'b0);
				send_pixel(k, 32'hffff_ffff, 32'h0000_0000, 1'b0);
			end
			// mix with both alphas zero gives zero
			send_pixel(K_MIX, 32'h00ab_cdef, 32'h0012_3456);
			// mix with negative interpolation
			send_pixel(K_MIX, 32'hc0ff_ffff, 32'hc000_0000);
			// copy with alpha bit clear and set
			send_pixel(K_COPY, 32'h1234_5678, 32'hffff_7fff);
			send_pixel(K_COPY, 32'h1234_5678, 32'h0000_8001);
			send_pixel(K_BLEND, 32'h80ff_0000, 32'h7f00_ff00);
		end
	endtask

	task automatic test_random(input int n);
		kind_t k;
		logic [31:0] bk;
		logic [31:0] fg;
		for (int i = 0; i < n; i++) begin
			k = kind_t'($urandom_range(0, 3));
			bk = rnd32();
			fg = rnd32();
			bk[31:24] = rnd_alpha();
			fg[31:24] = rnd_alpha();
			send_pixel(k, bk, fg, $urandom_range(0, 3) != 0 || i < 30 ? 1'b1 : 1'b0);
		end
	endtask

	// ---- result checker ----
	always @(posedge clk) begin
		pix_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pix.size() == 0) begin
				$display("%0t: unexpected beat pixel=%h we=%b", $time, m_tdata, m_tuser);
				err_cnt++;
			end else begin
				exp_r = pending_pix.pop_front();
				if (m_tdata !== exp_r.pixel) begin
					$display("%0t: new_pixel exp %h got %h", $time, exp_r.pixel, m_tdata);
					err_cnt++;
				end
				if (m_tuser !== exp_r.we) begin
					$display("%0t: write_enable exp %b got %b", $time, exp_r.we, m_tuser);
					err_cnt++;
				end
			end
		end
	end

	// receiver stalls: mostly ready, random short and occasional long stalls
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (stall_q > 0) begin
			m_tready <= 1'b0;
			stall_q <= stall_q - 1;
		end else if (r < 60) begin
			m_tready <= 1'b1;
		end else if (r < 97) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b0;
			stall_q <= $urandom_range(8, 40);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		pixel_format_we = 1'b0;
		pixel_format_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = K_BLEND;
		m_tready = 1'b0;
		fmt_1555 = 1'b1;
		err_cnt = 0;
		idle_cycles = 0;
		stall_q = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset value 1555 exercised before any write
		test_random(40);
		test_directed();
		set_format(1'b1);
		test_random(600);
		set_format(1'b0);
		test_random(600);
		// sender holds until everything is out, then resumes
		drain();
		test_random(300);
		set_format(1'b1);
		test_random(250);
		drain();
		if (err_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
design/abp_pkg.sv
design/abp_front.sv
design/abp_div_stage.sv
design/abp_chan.sv
design/argb_pixel_blend_unit_top.sv
sim/testbench.sv
